FILE: hdl/sequence_reorder_tracker_top_assert.svh
// assertion macros used by the port-level checker file
`ifndef SEQUENCE_REORDER_TRACKER_TOP_ASSERT_SVH
`define SEQUENCE_REORDER_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define SRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequence_reorder_tracker check failed");

// next-cycle implication, skipped while in reset
`define SRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequence_reorder_tracker check failed");

`endif

FILE: hdl/sro_pkg.sv
// shared types, constants and helpers for the sequence reorder tracker
package sro_pkg;

  localparam int WINDOW  = 16384;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = WINDOW / WORD_W;
  localparam int ADDR_W  = $clog2(WORDS);
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int ID_W    = 32;
  localparam int CNT_W   = 15;
  localparam int THR_W   = 16;
  localparam int RUN_W   = BIT_W + 1;
  localparam logic [THR_W-1:0] ACK_THR_RESET = 16'd3750;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLASSIFY,
    ST_RMW,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  release_first;
    logic [CNT_W-1:0] release_count;
    logic             dropped;
    logic             window_overflow;
    logic             ack_due;
    logic [ID_W-1:0]  ack_id;
  } res_t;

  // number of consecutive set bits starting at pos
  function automatic logic [RUN_W-1:0] ones_run(input logic [WORD_W-1:0] word,
                                                input logic [BIT_W-1:0] pos);
    logic [WORD_W-1:0] inv;
    logic [RUN_W-1:0]  run;
    logic              found;
    inv   = ~(word >> pos);
    run   = RUN_W'(WORD_W);
    found = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!found && inv[i]) begin
        run   = RUN_W'(i);
        found = 1'b1;
      end
    end
    return run;
  endfunction

endpackage

FILE: hdl/sro_ram.sv
// generic simple dual-port ram with registered read
module sro_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: hdl/sro_engine.sv
// window state, per-item classification and release-run scan over the bitmap
module sro_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sro_pkg::ID_W-1:0]   in_seq_id,
  input  logic                       cfg_valid,
  input  logic [sro_pkg::THR_W-1:0]  cfg_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output sro_pkg::res_t              res,
  output logic                       mem_we,
  output logic [sro_pkg::ADDR_W-1:0] mem_waddr,
  output logic [sro_pkg::WORD_W-1:0] mem_wdata,
  output logic [sro_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [sro_pkg::WORD_W-1:0] mem_rdata
);
  import sro_pkg::*;

  state_t            state_r, state_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   next_exp_r, next_exp_nxt;
  logic [ID_W-1:0]   first_miss_r, first_miss_nxt;
  logic              gap_r, gap_nxt;
  logic [ID_W-1:0]   conf_r, conf_nxt;
  logic [THR_W-1:0]  thr_r;
  logic [ID_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ID_W-1:0]   rel_first_r, rel_first_nxt;
  logic              drop_r, drop_nxt;
  logic              over_r, over_nxt;
  logic              ahead_r, ahead_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  logic [ID_W-1:0]   e_dist, d_dist, span, rem, j_adv, ack_span, ack_target;
  logic [RUN_W-1:0]  run, avail, tail;
  logic [BIT_W-1:0]  pos;
  logic              ack;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      next_exp_r <= '0;
      first_miss_r <= '0;
      gap_r      <= 1'b0;
      conf_r     <= '0;
      thr_r      <= ACK_THR_RESET;
      clr_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      next_exp_r <= next_exp_nxt;
      first_miss_r <= first_miss_nxt;
      gap_r      <= gap_nxt;
      conf_r     <= conf_nxt;
      clr_r      <= clr_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    j_r         <= j_nxt;
    cnt_r       <= cnt_nxt;
    rel_first_r <= rel_first_nxt;
    drop_r      <= drop_nxt;
    over_r      <= over_nxt;
    ahead_r     <= ahead_nxt;
  end

  assign e_dist   = id_r - next_exp_r;
  assign d_dist   = id_r - first_miss_r;
  assign span     = next_exp_r - first_miss_r;
  assign pos      = j_r[BIT_W-1:0];
  assign run      = ones_run(mem_rdata, pos);
  assign rem      = next_exp_r - j_r;
  assign avail    = (rem < ID_W'(run)) ? rem[RUN_W-1:0] : run;
  assign tail     = RUN_W'(WORD_W) - RUN_W'(pos);
  assign j_adv    = j_r + ID_W'(avail);
  assign ack_span = next_exp_r - conf_r;
  assign ack      = ack_span > ID_W'(thr_r);
  assign ack_target = gap_r ? first_miss_r : next_exp_r;

  always_comb begin
    state_nxt      = state_r;
    id_nxt         = id_r;
    next_exp_nxt   = next_exp_r;
    first_miss_nxt = first_miss_r;
    gap_nxt        = gap_r;
    conf_nxt       = conf_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    rel_first_nxt  = rel_first_r;
    drop_nxt       = drop_r;
    over_nxt       = over_r;
    ahead_nxt      = ahead_r;
    clr_nxt        = clr_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = id_r[SLOT_W-1:BIT_W];
    mem_wdata      = mem_rdata;
    mem_raddr      = id_r[SLOT_W-1:BIT_W];
    res.release_first   = rel_first_r;
    res.release_count   = cnt_r;
    res.dropped         = drop_r;
    res.window_overflow = over_r;
    res.ack_due         = ack;
    res.ack_id          = ack ? ack_target : '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          id_nxt        = in_seq_id;
          rel_first_nxt = '0;
          cnt_nxt       = '0;
          drop_nxt      = 1'b0;
          over_nxt      = 1'b0;
          ahead_nxt     = 1'b0;
          state_nxt     = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        state_nxt = ST_FINISH;
        if (!gap_r) begin
          if (e_dist == '0) begin
            rel_first_nxt = id_r;
            cnt_nxt       = CNT_W'(1);
            next_exp_nxt  = id_r + 1'b1;
          end else if (!e_dist[ID_W-1]) begin
            if (e_dist >= ID_W'(WINDOW)) begin
              over_nxt = 1'b1;
            end else begin
              ahead_nxt = 1'b1;
              state_nxt = ST_RMW;
            end
          end else begin
            drop_nxt = 1'b1;
          end
        end else begin
          if (d_dist < span) begin
            if (d_dist == '0) begin
              rel_first_nxt = id_r;
              cnt_nxt       = CNT_W'(1);
              j_nxt         = id_r + 1'b1;
              state_nxt     = ST_SCAN_RD;
            end else begin
              state_nxt = ST_RMW;
            end
          end else if (!e_dist[ID_W-1]) begin
            if (d_dist >= ID_W'(WINDOW)) begin
              over_nxt = 1'b1;
            end else begin
              ahead_nxt = 1'b1;
              state_nxt = ST_RMW;
            end
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      ST_RMW: begin
        state_nxt = ST_FINISH;
        // an in-gap id whose bit is already set is a duplicate
        if (!ahead_r && mem_rdata[id_r[BIT_W-1:0]]) begin
          drop_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (WORD_W'(1) << id_r[BIT_W-1:0]);
          if (ahead_r) begin
            next_exp_nxt = id_r + 1'b1;
            if (!gap_r) begin
              first_miss_nxt = next_exp_r;
              gap_nxt        = 1'b1;
            end
          end
        end
      end
      ST_SCAN_RD: begin
        mem_raddr = j_r[SLOT_W-1:BIT_W];
        state_nxt = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[SLOT_W-1:BIT_W];
        // clear the bits of the run being released
        for (int i = 0; i < WORD_W; i++) begin
          if (RUN_W'(i) >= RUN_W'(pos) && RUN_W'(i) < RUN_W'(pos) + avail) begin
            mem_wdata[i] = 1'b0;
          end
        end
        cnt_nxt = cnt_r + CNT_W'(avail);
        j_nxt   = j_adv;
        if (avail == tail && rem != ID_W'(avail)) begin
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_FINISH;
          if (j_adv == next_exp_r) begin
            gap_nxt = 1'b0;
          end else begin
            first_miss_nxt = j_adv;
          end
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (ack) begin
            conf_nxt = ack_target;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

FILE: hdl/sequence_reorder_tracker_top.sv
// sequence reorder tracker top level: engine, bitmap ram and result register
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_seq_id
// out      output     out_valid / out_ready  release, drop, overflow and ack fields
// cfg      input      cfg_valid / cfg_ready  cfg_ack_threshold
//
// an item goes through classify and finish when no bitmap access is needed, adds a
// bitmap read-modify-write when it sets its bit, and adds a read and a clear per 64-bit
// bitmap word touched by a release run (read the word, then find and clear the run).
// after reset a pass over all 256 words clears the bitmap; in_ready stays low.
// a result waits in the output register while the next item is worked on;
// the engine holds its finished result while that register is still full.
module sequence_reorder_tracker_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sro_pkg::ID_W-1:0]  in_seq_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sro_pkg::ID_W-1:0]  out_release_first,
  output logic [sro_pkg::CNT_W-1:0] out_release_count,
  output logic                      out_dropped,
  output logic                      out_window_overflow,
  output logic                      out_ack_due,
  output logic [sro_pkg::ID_W-1:0]  out_ack_id,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sro_pkg::THR_W-1:0] cfg_ack_threshold
);
  import sro_pkg::*;

  logic              res_valid, res_ready;
  res_t              res, out_r;
  logic              out_valid_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  sro_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_seq_id (in_seq_id),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_ack_threshold),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sro_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_release_first   = out_r.release_first;
  assign out_release_count   = out_r.release_count;
  assign out_dropped         = out_r.dropped;
  assign out_window_overflow = out_r.window_overflow;
  assign out_ack_due         = out_r.ack_due;
  assign out_ack_id          = out_r.ack_id;
endmodule

FILE: hdl/sro_checker.sv
// port-level checks for the sequence reorder tracker, bound to the top level
`include "sequence_reorder_tracker_top_assert.svh"

module sro_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sro_pkg::ID_W-1:0]  out_release_first,
  input logic [sro_pkg::CNT_W-1:0] out_release_count,
  input logic                      out_dropped,
  input logic                      out_window_overflow,
  input logic                      out_ack_due,
  input logic [sro_pkg::ID_W-1:0]  out_ack_id
);
  import sro_pkg::*;

  `SRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SRT_ASSERT_NOW(a_drop_excl, out_valid, !(out_dropped && out_window_overflow))
  `SRT_ASSERT_NOW(a_idle_first, out_valid && out_release_count == '0, out_release_first == '0)
  `SRT_ASSERT_NOW(a_ack_id_zero, out_valid && !out_ack_due, out_ack_id == '0)
  `SRT_ASSERT_NOW(a_release_clean, out_valid && out_release_count != '0,
                  !out_dropped && !out_window_overflow)
endmodule

bind sequence_reorder_tracker_top sro_checker u_sro_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_release_first   (out_release_first),
  .out_release_count   (out_release_count),
  .out_dropped         (out_dropped),
  .out_window_overflow (out_window_overflow),
  .out_ack_due         (out_ack_due),
  .out_ack_id          (out_ack_id)
);
